/* src/pfx_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
`timescale 1ns / 1ps

package pfx_pkg;

	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_MISSING  = 3'd1;
	localparam logic [2:0] STATUS_BADOP    = 3'd2;
	localparam logic [2:0] STATUS_OVERFLOW = 3'd3;
	localparam logic [2:0] STATUS_DIVZERO  = 3'd4;
	localparam logic [2:0] STATUS_NOTONE   = 3'd5;

	localparam logic [7:0] CH_MUL = 8'h2A; // '*'
	localparam logic [7:0] CH_DIV = 8'h2F; // '/'
	localparam logic [7:0] CH_REM = 8'h25; // '%'
	localparam logic [7:0] CH_ADD = 8'h2B; // '+'
	localparam logic [7:0] CH_SUB = 8'h2D; // '-'

	// Iteration counts of the serial unit, one bit per cycle
	localparam logic [5:0] MUL_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS = 6'd48;
	localparam logic [5:0] REM_STEPS = 6'd16;
	localparam logic [5:0] ADD_STEPS = 6'd32;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_DIV,
		OP_REM,
		OP_ADD,
		OP_SUB
	} alu_op_t;

	typedef struct packed {
		logic    known;
		alu_op_t op;
	} op_dec_t;

	typedef struct packed {
		logic              kind;
		logic signed [31:0] operand;
		logic [7:0]         op_char;
		logic               last;
	} token_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic [2:0]         status;
	} result_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} alu_rsp_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_FIN
	} alu_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_B,
		S_RD_A,
		S_CHECK,
		S_CALC,
		S_FINISH,
		S_EMIT
	} ctl_state_t;

	function automatic op_dec_t decode_op(input logic [7:0] ch);
		op_dec_t d;
		d.known = 1'b1;
		d.op    = OP_ADD;
		unique case (ch)
			CH_MUL:  d.op = OP_MUL;
			CH_DIV:  d.op = OP_DIV;
			CH_REM:  d.op = OP_REM;
			CH_ADD:  d.op = OP_ADD;
			CH_SUB:  d.op = OP_SUB;
			default: d.known = 1'b0;
		endcase
		return d;
	endfunction

	// Saturate a magnitude with a sign to signed 32 bits
	function automatic logic [31:0] sat_mag(input logic [47:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (m > 48'h0000_8000_0000) r = Q_MIN;
			else r = ~m[31:0] + 32'd1;
		end else begin
			if (m > 48'h0000_7FFF_FFFF) r = Q_MAX;
			else r = m[31:0];
		end
		return r;
	endfunction

endpackage

/* src/pfx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/pfx_alu.sv */
// Bit-serial Q16.16 arithmetic unit: multiply, divide, remainder, add, subtract.
`timescale 1ns / 1ps

module pfx_alu import pfx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  alu_req_t           req,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output alu_rsp_t           rsp
);

	alu_state_t  state_q, state_d;
	alu_op_t     op_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        c_q;
	logic        ovf_q;
	logic [31:0] d_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [47:0] dvd_q;
	logic [31:0] result_q;
	logic        done_q;

	logic [31:0] a_u, b_u, mag_a, mag_b;
	logic [32:0] mul_sum;
	logic [32:0] div_t, div_diff;
	logic        div_ge;
	logic        add_s, add_c;
	logic [47:0] mul_m;
	logic [31:0] rem_val;
	logic [31:0] fin_val;

	assign a_u   = a;
	assign b_u   = b;
	assign mag_a = a_u[31] ? ~a_u + 32'd1 : a_u;
	assign mag_b = b_u[31] ? ~b_u + 32'd1 : b_u;

	assign mul_sum  = {1'b0, hi_q} + {1'b0, (lo_q[0] ? d_q : 32'd0)};
	assign div_t    = {hi_q, dvd_q[47]};
	assign div_ge   = div_t >= {1'b0, d_q};
	assign div_diff = div_t - {1'b0, d_q};
	assign add_s    = hi_q[0] ^ d_q[0] ^ c_q;
	assign add_c    = (hi_q[0] & d_q[0]) | (c_q & (hi_q[0] ^ d_q[0]));

	// Negative products round toward minus infinity: bump the magnitude on lost bits
	assign mul_m   = {hi_q, lo_q[31:16]} + {47'd0, neg_q & (|lo_q[15:0])};
	assign rem_val = neg_q ? ~{hi_q[15:0], 16'd0} + 32'd1 : {hi_q[15:0], 16'd0};

	always_comb begin
		case (op_q) inside
			OP_MUL:         fin_val = sat_mag(mul_m, neg_q);
			OP_DIV:         fin_val = sat_mag(dvd_q, neg_q);
			OP_REM:         fin_val = rem_val;
			OP_ADD, OP_SUB: fin_val = ovf_q ? (lo_q[31] ? Q_MAX : Q_MIN) : lo_q;
			default:        fin_val = lo_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE:  if (req.start) state_d = A_RUN;
			A_RUN:   if (cnt_q == 6'd0) state_d = A_FIN;
			A_FIN:   state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == A_FIN);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					case (req.op) inside
						OP_MUL: begin
							hi_q  <= 32'd0;
							d_q   <= mag_a;
							lo_q  <= mag_b;
							neg_q <= a_u[31] ^ b_u[31];
							cnt_q <= MUL_STEPS - 6'd1;
						end
						OP_DIV: begin
							hi_q  <= 32'd0;
							dvd_q <= {mag_a, 16'd0};
							d_q   <= mag_b;
							neg_q <= a_u[31] ^ b_u[31];
							cnt_q <= DIV_STEPS - 6'd1;
						end
						OP_REM: begin
							// integer parts only; remainder takes the dividend's sign
							hi_q  <= 32'd0;
							dvd_q <= {mag_a[31:16], 32'd0};
							d_q   <= {16'd0, mag_b[31:16]};
							neg_q <= a_u[31];
							cnt_q <= REM_STEPS - 6'd1;
						end
						default: begin
							hi_q  <= a_u;
							d_q   <= (req.op == OP_SUB) ? ~b_u : b_u;
							c_q   <= (req.op == OP_SUB);
							cnt_q <= ADD_STEPS - 6'd1;
						end
					endcase
				end
			end
			A_RUN: begin
				cnt_q <= cnt_q - 6'd1;
				case (op_q) inside
					OP_MUL: begin
						hi_q <= mul_sum[32:1];
						lo_q <= {mul_sum[0], lo_q[31:1]};
					end
					OP_DIV, OP_REM: begin
						hi_q  <= div_ge ? div_diff[31:0] : div_t[31:0];
						dvd_q <= {dvd_q[46:0], div_ge};
					end
					default: begin
						hi_q  <= {1'b0, hi_q[31:1]};
						d_q   <= {1'b0, d_q[31:1]};
						lo_q  <= {add_s, lo_q[31:1]};
						c_q   <= add_c;
						// the last write holds the sign-bit overflow
						ovf_q <= c_q ^ add_c;
					end
				endcase
			end
			A_FIN: result_q <= fin_val;
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

/* src/postfix_expression_evaluator.sv */
// Postfix expression evaluator: token sequencer, operand stack and serial arithmetic.
// A number token passes through decode and finish; an operator also reads both stack
// operands, checks for division by zero and runs the serial unit (32 steps for * + -,
// 48 for /, 16 for %), one quotient or product bit per cycle. A last token then loads
// the result register once it is free. One token at a time; a new token is accepted
// while an earlier result waits. Reset clears the stack count, error latch and result
// valid; stack entries are not cleared.
`timescale 1ns / 1ps

module postfix_expression_evaluator import pfx_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  token_t  item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	ctl_state_t         state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [2:0]         err_q;
	token_t             tok_q;
	logic signed [31:0] a_q, b_q;
	logic               result_valid_q;
	result_t            result_q;

	logic [CNT_W-1:0] cnt_m1, cnt_m2;
	op_dec_t          dec;
	logic             b_int_zero, div_zero;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [31:0]      ram_wdata, ram_rdata;
	logic             cnt_inc, cnt_dec, err_set, out_load;
	logic [2:0]       err_code;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	result_t          out_d;

	assign cnt_m1 = count_q - CNT_W'(1);
	assign cnt_m2 = count_q - CNT_W'(2);
	assign dec    = decode_op(tok_q.op_char);

	assign b_int_zero = (b_q[31:16] == 16'h0000)
		|| (b_q[31:16] == 16'hFFFF && b_q[15:0] != 16'h0000);
	assign div_zero = (dec.op == OP_DIV && b_q == 32'sd0)
		|| (dec.op == OP_REM && b_int_zero);

	pfx_ram #(
		.WIDTH(32),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pfx_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (a_q),
		.b     (b_q),
		.rsp   (alu_rsp)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = tok_q.operand;
		ram_raddr = '0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		err_set   = 1'b0;
		err_code  = STATUS_OK;
		alu_req   = '{start: 1'b0, op: dec.op};
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_FINISH;
				if (err_q == STATUS_OK) begin
					if (!tok_q.kind) begin
						if (count_q == CNT_W'(STACK_DEPTH)) begin
							err_set  = 1'b1;
							err_code = STATUS_OVERFLOW;
						end else begin
							ram_we  = 1'b1;
							cnt_inc = 1'b1;
						end
					end else if (count_q < CNT_W'(2)) begin
						err_set  = 1'b1;
						err_code = STATUS_MISSING;
					end else if (!dec.known) begin
						err_set  = 1'b1;
						err_code = STATUS_BADOP;
					end else begin
						ram_raddr = cnt_m1[IDX_W-1:0];
						state_d   = S_RD_B;
					end
				end
			end
			S_RD_B: begin
				ram_raddr = cnt_m2[IDX_W-1:0];
				state_d   = S_RD_A;
			end
			S_RD_A: state_d = S_CHECK;
			S_CHECK: begin
				if (div_zero) begin
					err_set  = 1'b1;
					err_code = STATUS_DIVZERO;
					state_d  = S_FINISH;
				end else begin
					alu_req.start = 1'b1;
					state_d       = S_CALC;
				end
			end
			S_CALC: begin
				if (alu_rsp.done) begin
					// drop two operands, push the result in the lower slot
					ram_we    = 1'b1;
					ram_waddr = cnt_m2[IDX_W-1:0];
					ram_wdata = alu_rsp.result;
					cnt_dec   = 1'b1;
					state_d   = S_FINISH;
				end
			end
			S_FINISH: begin
				state_d = tok_q.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				// hold until the result register frees up
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		out_d.answer = 32'sd0;
		out_d.status = err_q;
		if (err_q == STATUS_OK) begin
			if (count_q != CNT_W'(1)) out_d.status = STATUS_NOTONE;
			else out_d.answer = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			err_q          <= STATUS_OK;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				count_q <= '0;
				err_q   <= STATUS_OK;
			end else begin
				if (cnt_inc) count_q <= count_q + CNT_W'(1);
				else if (cnt_dec) count_q <= cnt_m1;
				if (err_set) err_q <= err_code;
			end
			if (out_load) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) tok_q <= item;
		if (state_q == S_RD_B) b_q <= ram_rdata;
		if (state_q == S_RD_A) a_q <= ram_rdata;
		if (out_load) result_q <= out_d;
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
